// ===== rtl/core/rra_pkg.sv =====
// Package for the reference-counted register allocator.
// Holds sizes, request and status codes, and the word types. No dependencies.
`default_nettype none
package rra_pkg;

  localparam int NUM_REGS   = 256;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(NUM_REGS);
  localparam int HW_W       = IDX_W + 1;
  localparam int GRP_SIZE   = 16;
  localparam int GRP_W      = $clog2(GRP_SIZE);
  localparam int NUM_GRPS   = NUM_REGS / GRP_SIZE;
  localparam int NGRP_W     = IDX_W - GRP_W;

  typedef enum logic [1:0] {
    ACT_ALLOC     = 2'd0,
    ACT_ALLOC_ARG = 2'd1,
    ACT_REF       = 2'd2,
    ACT_UNREF     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNREF = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reg_res;
    logic [1:0] status;
    logic [8:0] used_count;
  } out_word_t;

  typedef struct packed {
    logic cap;
    logic srch;
    logic commit;
  } rra_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/refcounted_register_allocator.sv =====
// Top level of the reference-counted register allocator.
// Joins the controller and the datapath. Depends on rra_pkg, rra_ctrl, rra_dp.
//
// Usage: a request word (action, reg_index) enters on the in_ channel and one
// result word (reg_res, status, used_count) leaves on the out_ channel for
// every request. Both channels use a valid/ready handshake.
// Each request steps through a capture state (capture the word, read the count
// memory), a search state (register the sixteen-group free and used search over
// the free bitmap) and an execute state (combine groups, write the count memory
// back, load the output register). A new request is accepted only once the last
// is written back, set by that read-search-write sequence on the count memory.
// The result appears in the cycle after the write-back.
// The output register decouples the two sides: a new request is accepted
// while a result waits; if the receiver still stalls when the next result is
// ready, the block holds in its last step until the output register empties.
// Reset (synchronous, active low) clears the high-water mark, the free bitmap
// and the per-register valid bits, so every count reads as zero at once; no
// clearing pass is needed and a request may be accepted right after reset.
`default_nettype none
module refcounted_register_allocator
  import rra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  rra_cmd_t cmd;

  // Sequencer: owns the handshakes and steps each request through its cycles.
  rra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: allocator state, search and result register.
  rra_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/rra_ctrl.sv =====
// Controller for the register allocator: request sequencing and handshakes.
// Depends on rra_pkg.
`default_nettype none
module rra_ctrl
  import rra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output rra_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.cap    = (state_r == S_IDLE) && in_valid;
    cmd.srch   = (state_r == S_SRCH);
    cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SRCH;
      S_SRCH: state_nxt = S_EXEC;
      S_EXEC: if (cmd.commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/rra_dp.sv =====
// Datapath for the register allocator: high-water mark, free bitmap, count memory,
// two-level free/used search and the result register. Depends on rra_pkg.
`default_nettype none
module rra_dp
  import rra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rra_cmd_t cmd,
  input  wire in_word_t in_data,
  output out_word_t     out_data
);

  logic [HW_W-1:0]       hw_r;
  logic [NUM_REGS-1:0]   free_r;
  logic [NUM_REGS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] cnt_mem [NUM_REGS];

  logic [1:0]            act_r;
  logic [IDX_W-1:0]      idx_r;
  logic [COUNT_BITS-1:0] rd_r;
  logic                  rdv_r;

  logic [NUM_GRPS-1:0]   gfree_r, gused_r;
  logic [GRP_W-1:0]      gflo_r [NUM_GRPS];
  logic [GRP_W-1:0]      guhi_r [NUM_GRPS];
  out_word_t             out_r;

  // Group search terms.
  logic [NUM_REGS-1:0]   used_vec;
  logic [NUM_GRPS-1:0]   gfree_nxt, gused_nxt;
  logic [GRP_W-1:0]      gflo_nxt [NUM_GRPS];
  logic [GRP_W-1:0]      guhi_nxt [NUM_GRPS];

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      used_vec[i] = !free_r[i] && (HW_W'(i) < hw_r);
    end
    for (int g = 0; g < NUM_GRPS; g++) begin
      gfree_nxt[g] = |free_r[g*GRP_SIZE +: GRP_SIZE];
      gused_nxt[g] = |used_vec[g*GRP_SIZE +: GRP_SIZE];
      gflo_nxt[g]  = '0;
      guhi_nxt[g]  = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (free_r[g*GRP_SIZE + b]) gflo_nxt[g] = GRP_W'(b);
      end
      for (int b = 0; b < GRP_SIZE; b++) begin
        if (used_vec[g*GRP_SIZE + b]) guhi_nxt[g] = GRP_W'(b);
      end
    end
  end

  // Final selection and request execution.
  logic                  any_free, any_used;
  logic [IDX_W-1:0]      lo_free, hi_used;
  logic [HW_W-1:0]       arg_sel;
  logic [COUNT_BITS-1:0] cnt, wr_data;
  logic [IDX_W-1:0]      wr_addr, res;
  logic                  wr_en, clr_free, set_free, grow;
  status_t               status;

  always_comb begin
    any_free = 1'b0;
    any_used = 1'b0;
    lo_free  = '0;
    hi_used  = '0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (gfree_r[g]) begin
        any_free = 1'b1;
        lo_free  = {NGRP_W'(g), gflo_r[g]};
      end
    end
    for (int g = 0; g < NUM_GRPS; g++) begin
      if (gused_r[g]) begin
        any_used = 1'b1;
        hi_used  = {NGRP_W'(g), guhi_r[g]};
      end
    end
    arg_sel  = any_used ? ({1'b0, hi_used} + HW_W'(1)) : '0;
    cnt      = rdv_r ? rd_r : '0;
    res      = idx_r;
    status   = ST_OK;
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = COUNT_BITS'(1);
    clr_free = 1'b0;
    set_free = 1'b0;
    grow     = 1'b0;
    case (act_r)
      ACT_ALLOC: begin
        if (any_free) begin
          res = lo_free; wr_en = 1'b1; clr_free = 1'b1;
        end else if (hw_r == HW_W'(NUM_REGS)) begin
          status = ST_FULL; res = '0;
        end else begin
          res = hw_r[IDX_W-1:0]; wr_en = 1'b1; grow = 1'b1;
        end
      end
      ACT_ALLOC_ARG: begin
        if (arg_sel == hw_r) begin
          if (hw_r == HW_W'(NUM_REGS)) begin
            status = ST_FULL; res = '0;
          end else begin
            res = hw_r[IDX_W-1:0]; wr_en = 1'b1; grow = 1'b1;
          end
        end else begin
          res = arg_sel[IDX_W-1:0]; wr_en = 1'b1; clr_free = 1'b1;
        end
      end
      ACT_REF: begin
        if (cnt == '0) status = ST_UNREF;
        else if (cnt == {COUNT_BITS{1'b1}}) status = ST_SAT;
        else begin
          wr_en = 1'b1; wr_data = cnt + COUNT_BITS'(1);
        end
      end
      default: begin
        if (cnt == '0) status = ST_UNREF;
        else begin
          wr_en = 1'b1; wr_data = cnt - COUNT_BITS'(1);
          set_free = (cnt == COUNT_BITS'(1));
        end
      end
    endcase
    wr_addr = res;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_data.action;
      idx_r <= in_data.reg_index[IDX_W-1:0];
      rd_r  <= cnt_mem[in_data.reg_index[IDX_W-1:0]];
      rdv_r <= vld_r[in_data.reg_index[IDX_W-1:0]];
    end
    if (cmd.srch) begin
      gfree_r <= gfree_nxt;
      gused_r <= gused_nxt;
      for (int g = 0; g < NUM_GRPS; g++) begin
        gflo_r[g] <= gflo_nxt[g];
        guhi_r[g] <= guhi_nxt[g];
      end
    end
    if (cmd.commit && wr_en) cnt_mem[wr_addr] <= wr_data;
    if (cmd.commit) begin
      out_r.reg_res    <= 8'(res);
      out_r.status     <= status;
      out_r.used_count <= 9'(grow ? (hw_r + HW_W'(1)) : hw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= '0;
      free_r <= '0;
      vld_r  <= '0;
    end else if (cmd.commit) begin
      if (grow) hw_r <= hw_r + HW_W'(1);
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (clr_free) free_r[wr_addr] <= 1'b0;
      if (set_free) free_r[wr_addr] <= 1'b1;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire
